### hdl/trf_pkg.sv
// Shared types, protocol constants and reply byte helpers of the telnet receive filter.
`default_nettype none

package trf_pkg;

   // Telnet command and option bytes
   localparam logic [7:0] CMD_IAC   = 8'd255;
   localparam logic [7:0] CMD_SB    = 8'd250;
   localparam logic [7:0] CMD_SE    = 8'd240;
   localparam logic [7:0] CMD_WILL  = 8'd251;
   localparam logic [7:0] CMD_WONT  = 8'd252;
   localparam logic [7:0] CMD_DO    = 8'd253;
   localparam logic [7:0] CMD_DONT  = 8'd254;
   localparam logic [7:0] OPT_ECHO  = 8'd1;
   localparam logic [7:0] OPT_SGA   = 8'd3;
   localparam logic [7:0] OPT_TTYPE = 8'd24;
   localparam logic [7:0] TT_IS     = 8'd0;
   localparam logic [7:0] TT_SEND   = 8'd1;
   localparam logic [7:0] CHAR_NUL  = 8'd0;
   localparam logic [7:0] CHAR_ESC  = 8'd27;
   localparam logic [7:0] ESC_FINAL = 8'd64;

   // Configuration register indexes
   localparam logic REG_ECHO = 1'b0;
   localparam logic REG_SUPP = 1'b1;

   // Descriptor queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Longest burst is ten bytes
   localparam int BURST_CW = 4;

   typedef enum logic [1:0] {
      PHASE_DATA,
      PHASE_CMD,
      PHASE_OPTION
   } phase_type;

   typedef enum logic [2:0] {
      PEER_SB,
      PEER_WILL,
      PEER_WONT,
      PEER_DO,
      PEER_DONT
   } verb_type;

   typedef enum logic [1:0] {
      HANDLER_NVT,
      HANDLER_ANSI,
      HANDLER_DISCARD,
      HANDLER_TTYPE
   } handler_type;

   typedef enum logic [1:0] {
      ESC_NORMAL,
      ESC_AFTER,
      ESC_SEQ
   } esc_type;

   // Reply verb, offset from the WILL byte
   typedef enum logic [1:0] {
      REPLY_WILL,
      REPLY_WONT,
      REPLY_DO,
      REPLY_DONT
   } reply_type;

   typedef enum logic [1:0] {
      BURST_DATA,
      BURST_NEG,
      BURST_TERM
   } burst_kind_type;

   // One input byte's output burst in compact form.
   // For data bursts the console byte travels in opt[0].
   typedef struct packed {
      burst_kind_type          kind;
      logic [BURST_CW-1:0]     count;
      logic                    ansi;
      reply_type [2:0]         verb;
      logic [2:0][7:0]         opt;
   } burst_type;

   // Confirming answer to a request
   function automatic reply_type yes_reply(verb_type v);
      reply_type r;
      unique case (v)
         PEER_WILL: r = REPLY_DO;
         PEER_WONT: r = REPLY_DONT;
         PEER_DO:   r = REPLY_WILL;
         default:   r = REPLY_WONT;
      endcase
      return r;
   endfunction

   // Refusing answer to a request
   function automatic reply_type no_reply(verb_type v);
      reply_type r;
      unique case (v)
         PEER_WILL: r = REPLY_DONT;
         PEER_WONT: r = REPLY_DO;
         PEER_DO:   r = REPLY_WONT;
         default:   r = REPLY_WILL;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] reply_byte(reply_type r);
      return CMD_WILL + {6'b0, r};
   endfunction

   // Byte at position idx of a burst
   function automatic logic [7:0] burst_byte(burst_type b, logic [BURST_CW-1:0] idx);
      logic [7:0] r;
      r = CMD_IAC;
      unique case (b.kind)
         BURST_DATA: r = b.opt[0];
         BURST_NEG: begin
            unique case (idx)
               4'd1:    r = reply_byte(b.verb[0]);
               4'd2:    r = b.opt[0];
               4'd4:    r = reply_byte(b.verb[1]);
               4'd5:    r = b.opt[1];
               4'd7:    r = reply_byte(b.verb[2]);
               4'd8:    r = b.opt[2];
               default: r = CMD_IAC;
            endcase
         end
         BURST_TERM: begin
            unique case (idx)
               4'd0:    r = CMD_IAC;
               4'd1:    r = CMD_SB;
               4'd2:    r = OPT_TTYPE;
               4'd3:    r = TT_IS;
               4'd4:    r = b.ansi ? 8'h41 : 8'h4E;
               4'd5:    r = b.ansi ? 8'h4E : 8'h56;
               4'd6:    r = b.ansi ? 8'h53 : 8'h54;
               4'd7:    r = b.ansi ? 8'h49 : CMD_IAC;
               4'd8:    r = b.ansi ? CMD_IAC : CMD_SE;
               default: r = CMD_SE;
            endcase
         end
         default: r = CMD_IAC;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/telnet_receive_filter.sv
// Top level of the telnet receive filter: register port, parser, queue and expander.
//
// Usage:
//   Input channel (req_*): one received telnet byte per transfer on req_rx_byte.
//   Result channel (rsp_*): console bytes (rsp_out_dest 0) and reply bytes for the
//   peer (rsp_out_dest 1); rsp_out_last marks the final byte caused by one input.
//   An input byte yields zero to ten result bytes.
//   Register port (csr_*): echo_already_set at 0x0, supp_already_set at 0x4, bit 0.
//   Write only while the block is idle.
// Timing:
//   The first result of a byte passes the queue entry, the current-burst register and
//   the output register. One input byte is taken per cycle while req_stall is low;
//   results leave one per cycle while rsp_stall is low. A four-entry
//   descriptor queue absorbs bursts; req_stall rises while it is full.
// Reset:
//   Synchronous, active high. Protocol state returns to the data phase with the
//   NVT handler and terminal index zero; queue and output register are emptied.
// Stall:
//   While rsp_stall is high the held result does not change; the queue fills and
//   then req_stall stops further input.
`default_nettype none

module telnet_receive_filter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_out_dest,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import trf_pkg::*;

   logic       echo_ff, echo_in;
   logic       supp_ff, supp_in;
   logic       csr_write;
   logic       req_accept;
   logic       desc_valid;
   burst_type  desc;
   logic       head_valid;
   burst_type  head_data;
   logic       pop;
   logic       queue_full;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      echo_in = echo_ff;
      supp_in = supp_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_ECHO: echo_in = csr_pwdata[0];
            REG_SUPP: supp_in = csr_pwdata[0];
            default: ;
         endcase
      end
      csr_prdata = {31'b0, (csr_paddr[2] == REG_SUPP) ? supp_ff : echo_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_ff <= 1'b0;
         supp_ff <= 1'b0;
      end else begin
         echo_ff <= echo_in;
         supp_ff <= supp_in;
      end
   end

   // Input transfer
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;

   trf_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .rx_byte    (req_rx_byte),
      .echo_set   (echo_ff),
      .supp_set   (supp_ff),
      .desc_valid (desc_valid),
      .desc       (desc)
   );

   trf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept && desc_valid),
      .push_data  (desc),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .full       (queue_full)
   );

   trf_expander u_expander (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_dest   (rsp_out_dest),
      .rsp_byte   (rsp_out_byte),
      .rsp_last   (rsp_out_last)
   );

`ifndef SYNTHESIS
   // no input is taken while the queue is full
   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !req_accept)
      else $error("input taken with full queue");
`endif

endmodule

`default_nettype wire

### hdl/trf_parser.sv
// Protocol state machine: tracks IAC sequences and builds at most one burst descriptor per byte.
`default_nettype none

module trf_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        rx_byte,
   input  wire logic              echo_set,
   input  wire logic              supp_set,
   output logic                   desc_valid,
   output trf_pkg::burst_type     desc
);
   import trf_pkg::*;

   phase_type   phase_ff,   phase_in;
   verb_type    verb_ff,    verb_in;
   handler_type handler_ff, handler_in;
   esc_type     esc_ff,     esc_in;
   logic [1:0]  term_ff,    term_in;
   logic        run_data;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_DATA;
         verb_ff    <= PEER_SB;
         handler_ff <= HANDLER_NVT;
         esc_ff     <= ESC_NORMAL;
         term_ff    <= 2'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         verb_ff    <= verb_in;
         handler_ff <= handler_in;
         esc_ff     <= esc_in;
         term_ff    <= term_in;
      end
   end

   // Next state and burst descriptor for the byte on the input
   always_comb begin
      phase_in   = PHASE_DATA;
      verb_in    = verb_ff;
      handler_in = handler_ff;
      esc_in     = esc_ff;
      term_in    = term_ff;
      run_data   = 1'b0;
      desc_valid = 1'b0;
      desc       = '0;
      desc.kind  = BURST_DATA;

      unique case (phase_ff)
         PHASE_DATA: begin
            if (rx_byte == CMD_IAC) phase_in = PHASE_CMD;
            else run_data = 1'b1;
         end
         PHASE_CMD: begin
            // escaped 255 goes to the data handler; unlisted commands drop out
            if (rx_byte == CMD_IAC) begin
               run_data = 1'b1;
            end else if (rx_byte == CMD_SE) begin
               handler_in = (term_ff == 2'd0) ? HANDLER_NVT : HANDLER_ANSI;
            end else if (rx_byte >= CMD_SB && rx_byte <= CMD_DONT) begin
               verb_in  = verb_type'(3'(rx_byte - CMD_SB));
               phase_in = PHASE_OPTION;
            end
         end
         PHASE_OPTION: begin
            desc.kind = BURST_NEG;
            if (verb_ff == PEER_SB) begin
               handler_in = (rx_byte == OPT_TTYPE) ? HANDLER_TTYPE : HANDLER_DISCARD;
            end else if (rx_byte == OPT_ECHO) begin
               if (!((verb_ff == PEER_WILL && echo_set) ||
                     (verb_ff == PEER_WONT && !echo_set))) begin
                  desc_valid   = 1'b1;
                  desc.count   = 4'd3;
                  desc.verb[0] = (verb_ff == PEER_DO) ? REPLY_WONT : yes_reply(verb_ff);
                  desc.opt[0]  = OPT_ECHO;
               end
            end else if (rx_byte == OPT_SGA) begin
               desc.opt[0] = OPT_SGA;
               desc.opt[1] = OPT_SGA;
               desc.opt[2] = OPT_ECHO;
               if (verb_ff == PEER_WILL && !supp_set) begin
                  desc_valid   = 1'b1;
                  desc.count   = 4'd9;
                  desc.verb[0] = REPLY_DO;
                  desc.verb[1] = REPLY_WILL;
                  desc.verb[2] = REPLY_DO;
               end else if (verb_ff == PEER_WONT && supp_set) begin
                  desc_valid   = 1'b1;
                  desc.count   = 4'd6;
                  desc.verb[0] = REPLY_DONT;
                  desc.verb[1] = REPLY_WONT;
               end else if (verb_ff == PEER_DO && !supp_set) begin
                  desc_valid   = 1'b1;
                  desc.count   = 4'd3;
                  desc.verb[0] = REPLY_DO;
               end else if (verb_ff == PEER_DONT && supp_set) begin
                  desc_valid   = 1'b1;
                  desc.count   = 4'd3;
                  desc.verb[0] = REPLY_DONT;
               end
            end else if (rx_byte == OPT_TTYPE) begin
               desc.opt[0] = OPT_TTYPE;
               desc.count  = 4'd3;
               if (verb_ff == PEER_WILL) begin
                  desc_valid   = 1'b1;
                  desc.verb[0] = no_reply(verb_ff);
               end else if (verb_ff == PEER_DO) begin
                  desc_valid   = 1'b1;
                  desc.verb[0] = yes_reply(verb_ff);
               end
            end else begin
               // unknown option: refuse requests, ignore the rest
               desc.opt[0] = rx_byte;
               desc.count  = 4'd3;
               if (verb_ff == PEER_WILL || verb_ff == PEER_DO) begin
                  desc_valid   = 1'b1;
                  desc.verb[0] = no_reply(verb_ff);
               end
            end
         end
         default: phase_in = PHASE_DATA;
      endcase

      // Data handlers
      if (run_data) begin
         unique case (handler_ff)
            HANDLER_NVT: begin
               if (rx_byte != CHAR_NUL) begin
                  desc_valid  = 1'b1;
                  desc.kind   = BURST_DATA;
                  desc.count  = 4'd1;
                  desc.opt[0] = rx_byte;
               end
            end
            HANDLER_ANSI: begin
               if (esc_ff == ESC_NORMAL) begin
                  if (rx_byte == CHAR_ESC) begin
                     esc_in = ESC_AFTER;
                  end else if (rx_byte != CHAR_NUL) begin
                     desc_valid  = 1'b1;
                     desc.kind   = BURST_DATA;
                     desc.count  = 4'd1;
                     desc.opt[0] = rx_byte;
                  end
               end else if (esc_ff == ESC_AFTER) begin
                  esc_in = ESC_SEQ;
               end else if (rx_byte > ESC_FINAL) begin
                  esc_in = ESC_NORMAL;
               end
            end
            HANDLER_TTYPE: begin
               if (rx_byte == TT_SEND) begin
                  term_in    = (term_ff >= 2'd2) ? 2'd0 : term_ff + 2'd1;
                  desc_valid = 1'b1;
                  desc.kind  = BURST_TERM;
                  desc.ansi  = (term_in != 2'd0);
                  desc.count = (term_in != 2'd0) ? 4'd10 : 4'd9;
               end
            end
            default: ;
         endcase
      end
   end

`ifndef SYNTHESIS
   // IAC in the data phase always opens a command
   a_iac_opens_cmd: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PHASE_DATA && rx_byte == CMD_IAC |=> phase_ff == PHASE_CMD)
      else $error("IAC did not open a command");

   // terminal index cycles through three values only
   a_term_range: assert property (@(posedge clock) disable iff (reset)
      term_ff != 2'd3)
      else $error("terminal index out of range");

   // a descriptor always carries at least one byte and at most ten
   a_desc_count: assert property (@(posedge clock) disable iff (reset)
      desc_valid |-> desc.count != 4'd0 && desc.count <= 4'd10)
      else $error("bad burst length");
`endif

endmodule

`default_nettype wire

### hdl/trf_queue.sv
// Small flop-based queue of burst descriptors between parser and byte expander.
`default_nettype none

module trf_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire trf_pkg::burst_type push_data,
   input  wire logic              pop,
   output logic                   head_valid,
   output trf_pkg::burst_type     head_data,
   output logic                   full
);
   import trf_pkg::*;

   burst_type             q_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff,  count_in;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= push_data;
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = q_ff[rd_ptr_ff];
   assign full       = (count_ff == QUEUE_CW'(QUEUE_DEPTH));

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("descriptor queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("descriptor queue underflow");
`endif

endmodule

`default_nettype wire

### hdl/trf_expander.sv
// Expands burst descriptors into output register bytes, one per cycle unless stalled.
`default_nettype none

module trf_expander (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire trf_pkg::burst_type head_data,
   output logic                   pop,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output logic                   rsp_dest,
   output logic [7:0]             rsp_byte,
   output logic                   rsp_last
);
   import trf_pkg::*;

   burst_type              cur_ff,       cur_in;
   logic                   cur_valid_ff, cur_valid_in;
   logic [BURST_CW-1:0]    idx_ff,       idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_dest_ff,  rsp_dest_in;
   logic [7:0]             rsp_byte_ff,  rsp_byte_in;
   logic                   rsp_last_ff,  rsp_last_in;
   logic                   slot_free;
   logic                   load;
   logic                   at_end;

   // Move one byte into the output register whenever it is free or draining
   always_comb begin
      slot_free    = !rsp_valid_ff || !rsp_stall;
      load         = cur_valid_ff && slot_free;
      at_end       = (idx_ff == cur_ff.count - 1'b1);
      pop          = head_valid && (!cur_valid_ff || (load && at_end));

      rsp_valid_in = slot_free ? load : rsp_valid_ff;
      rsp_dest_in  = rsp_dest_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_dest_in = (cur_ff.kind != BURST_DATA);
         rsp_byte_in = burst_byte(cur_ff, idx_ff);
         rsp_last_in = at_end;
      end

      cur_in       = pop ? head_data : cur_ff;
      cur_valid_in = pop ? 1'b1 : (cur_valid_ff && !(load && at_end));
      idx_in       = pop ? '0 : (load ? idx_ff + 1'b1 : idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_dest_ff <= rsp_dest_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_dest  = rsp_dest_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_last  = rsp_last_ff;

`ifndef SYNTHESIS
   // byte index stays inside the current burst
   a_idx_in_burst: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> idx_ff < cur_ff.count)
      else $error("burst index past end");

   // a burst that ends frees the slot for the next one
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      load && at_end && !head_valid |=> !cur_valid_ff)
      else $error("finished burst still active");
`endif

endmodule

`default_nettype wire
